@@ rtl/npr_pkg.sv @@
// Package for the nearest palette pen remap block: sizes, codes, the tag that
// follows a palette read through the distance unit, and colour helpers.
// Used by npr_if, npr_dist_unit and the core; depends on nothing.
package npr_pkg;

  localparam int unsigned PENS      = 32;
  localparam int unsigned PEN_AW    = $clog2(PENS);
  localparam int unsigned PEN_W     = 5;
  localparam int unsigned WORD_W    = 12;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SQ_W      = 2 * CHAN_W;
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PEN_AW-1:0] FIRST_PEN = PEN_AW'(1);
  localparam logic [PEN_AW-1:0] LAST_PEN  = PEN_AW'(PENS - 1);
  // Above any real distance (3 * 255 * 255), so the first entry always wins.
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_ENABLE    = 2'd0,
    CFG_PALETTE_READY = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_REMAP = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic [PEN_AW-1:0] idx;
  } npr_tag_t;

  // Multiplying a nibble by 17 is the same as repeating it in both halves.
  function automatic logic [COLOR_W-1:0] expand_word(input logic [WORD_W-1:0] w);
    return {w[11:8], w[11:8], w[7:4], w[7:4], w[3:0], w[3:0]};
  endfunction

  function automatic logic pen_in_range(input logic [PEN_W-1:0] p);
    return (32'(p) < 32'(PENS));
  endfunction

endpackage

@@ rtl/npr_if.sv @@
// Channel interfaces of the nearest palette pen remap block: request items,
// result items and configuration writes. Depends on npr_pkg.
interface npr_in_if;
  import npr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [PEN_W-1:0]     pen_index;
  logic [WORD_W-1:0]    color_word;
  logic [COLOR_W-1:0]   host_color;
  modport source (output valid, req_type, pen_index, color_word, host_color, input ready);
  modport sink   (input valid, req_type, pen_index, color_word, host_color, output ready);
endinterface

interface npr_out_if;
  import npr_pkg::*;
  logic                valid;
  logic                ready;
  logic [PEN_W-1:0]    mapped_pen;
  logic [DIST_W-1:0]   best_distance;
  modport source (output valid, mapped_pen, best_distance, input ready);
  modport sink   (input valid, mapped_pen, best_distance, output ready);
endinterface

interface npr_cfg_if;
  import npr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/npr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Self-contained; used for the host palette store.
module npr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/npr_dist_unit.sv @@
// Shared squared-distance unit: two register stages, channel squares then
// their sum, with the palette read tag carried alongside. Depends on npr_pkg.
module npr_dist_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  npr_pkg::npr_tag_t       tag_i,
  input  logic [npr_pkg::COLOR_W-1:0] ref_i,
  input  logic [npr_pkg::COLOR_W-1:0] entry_i,
  output npr_pkg::npr_tag_t       tag_o,
  output logic [npr_pkg::DIST_W-1:0]  dist_o
);
  import npr_pkg::*;

  logic [CHAN_W-1:0] diff [3];
  logic [SQ_W-1:0]   sq_d [3];
  logic [SQ_W-1:0]   sq_q [3];
  npr_tag_t          tag1_q;
  npr_tag_t          tag2_q;
  logic [DIST_W-1:0] dist_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      a = ref_i[c*CHAN_W +: CHAN_W];
      b = entry_i[c*CHAN_W +: CHAN_W];
      diff[c] = (a > b) ? (a - b) : (b - a);
      sq_d[c] = diff[c] * diff[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    dist_q <= DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2]);
  end

  assign tag_o  = tag2_q;
  assign dist_o = dist_q;

endmodule

@@ rtl/nearest_palette_pen_remap_core.sv @@
// Top level of the nearest palette pen remap block: sequencer, best-match
// tracking, configuration and result register.
// Depends on npr_pkg, npr_if, npr_ram and npr_dist_unit.

// A load transaction writes one host palette entry and produces no result. A
// remap transaction with mapping enabled and the palette ready reads host
// entries 1 to PENS-1 through the single palette read port, one per cycle,
// into one squared-distance unit; no further transaction is taken until its
// result has been moved into the result register. An identity remap (mapping
// off, palette not ready, pen zero or a pen beyond the palette) skips the
// search. The input is not ready while a remap is in progress; the result
// register lets a load be taken while a result waits to be collected.
// Entries that were never loaded must not be searched; their contents are
// undefined after reset.
module nearest_palette_pen_remap_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  npr_in_if.sink    in_i,
  npr_out_if.source out_o,
  npr_cfg_if.sink   cfg_i
);
  import npr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic map_enable_q, palette_ready_q;

  logic              in_acc;
  logic              is_load;
  logic              mapping;
  logic              ram_we;
  logic [COLOR_W-1:0] ram_rdata;

  logic [COLOR_W-1:0] ref_q, ref_d;
  logic [PEN_AW-1:0]  cnt_q, cnt_d;
  logic               issuing_q, issuing_d;
  npr_tag_t           rd_tag_q, rd_tag_d;
  npr_tag_t           dist_tag;
  logic [DIST_W-1:0]  cur_dist;

  logic [PEN_W-1:0]  best_pen_q, best_pen_d;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic              take;

  logic              out_valid_q, out_valid_d;
  logic [PEN_W-1:0]  out_pen_q, out_pen_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic              out_load;

  // Configuration port.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_enable_q    <= 1'b0;
      palette_ready_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAP_ENABLE:    map_enable_q    <= cfg_i.data;
        CFG_PALETTE_READY: palette_ready_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input side.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_load    = (in_i.req_type == REQ_LOAD);
  assign ram_we     = in_acc && is_load && pen_in_range(in_i.pen_index);
  assign mapping    = map_enable_q && palette_ready_q && pen_in_range(in_i.pen_index)
                      && (in_i.pen_index != '0);

  npr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PENS)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (PEN_AW'(in_i.pen_index)),
    .wdata_i (in_i.host_color),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  npr_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (rd_tag_q),
    .ref_i   (ref_q),
    .entry_i (ram_rdata),
    .tag_o   (dist_tag),
    .dist_o  (cur_dist)
  );

  assign take     = dist_tag.vld && (cur_dist < best_dist_q);
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    ref_d       = ref_q;
    cnt_d       = cnt_q;
    issuing_d   = issuing_q;
    best_pen_d  = best_pen_q;
    best_dist_d = best_dist_q;

    rd_tag_d.vld  = issuing_q;
    rd_tag_d.last = (cnt_q == LAST_PEN);
    rd_tag_d.idx  = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !is_load) begin
          ref_d = expand_word(in_i.color_word);
          if (mapping) begin
            cnt_d       = FIRST_PEN;
            issuing_d   = 1'b1;
            best_pen_d  = PEN_W'(FIRST_PEN);
            best_dist_d = DIST_INIT;
            state_d     = ST_SWEEP;
          end else begin
            // Identity result; pen zero maps to zero, which is the same value.
            best_pen_d  = in_i.pen_index;
            best_dist_d = '0;
            state_d     = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        if (issuing_q) begin
          cnt_d = cnt_q + PEN_AW'(1);
          if (cnt_q == LAST_PEN) begin
            issuing_d = 1'b0;
          end
        end
        if (take) begin
          best_pen_d  = PEN_W'(dist_tag.idx);
          best_dist_d = cur_dist;
        end
        if (dist_tag.vld && dist_tag.last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issuing_q <= 1'b0;
      rd_tag_q  <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      issuing_q <= issuing_d;
      rd_tag_q  <= rd_tag_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q       <= ref_d;
    best_pen_q  <= best_pen_d;
    best_dist_q <= best_dist_d;
  end

  // Result register; a finished result waits here until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    out_pen_d   = out_pen_q;
    out_dist_d  = out_dist_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_pen_d   = best_pen_q;
      out_dist_d  = best_dist_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pen_q  <= out_pen_d;
    out_dist_q <= out_dist_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.mapped_pen    = out_pen_q;
  assign out_o.best_distance = out_dist_q;

endmodule
